>>> rtl/lens_undistort_remap_coords_macros.svh
// Assertion macros used by the lens remap top level.
`ifndef LENS_UNDISTORT_REMAP_COORDS_MACROS_SVH
`define LENS_UNDISTORT_REMAP_COORDS_MACROS_SVH
`ifndef SYNTHESIS
`define LUR_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("lur: same-cycle check failed");
`define LUR_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("lur: next-cycle check failed");
`else
`define LUR_ASSERT_NOW(lbl, clk, rst_n, pre, post)
`define LUR_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

>>> rtl/lur_pkg.sv
// Types, constants and helper functions for the lens remap pipeline.
package lur_pkg;

    localparam int QW         = 48;
    localparam int SUM_W      = 51;
    localparam int NORM_FRAC  = 28;
    localparam int FOCAL_FRAC = 8;
    localparam int FOCAL_W    = 24;
    localparam int COEF_W     = 32;
    localparam int DIM_W      = 16;
    localparam int POS_W      = 22;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;

    typedef logic signed [QW-1:0]    t_q;
    typedef logic signed [SUM_W-1:0] t_sum;

    localparam t_q Q_LIM = {1'b0, {(QW-1){1'b1}}};
    localparam t_q Q_ONE = t_q'(64'd1 << NORM_FRAC);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOCAL   = 4'd0,
        CFG_CENTER  = 4'd1,
        CFG_K1      = 4'd2,
        CFG_K2      = 4'd3,
        CFG_K3      = 4'd4,
        CFG_K4      = 4'd5,
        CFG_TANGENT = 4'd6,
        CFG_SIZE    = 4'd7
    } t_cfg_idx;

    // Bits needed for the magnitude of an input position minus the center.
    function automatic int diff_mag_w(input int frac);
        return (frac > 8) ? 14 + frac : 22;
    endfunction

    function automatic t_q sat_q(input t_sum v);
        if (v > t_sum'(Q_LIM)) begin
            sat_q = Q_LIM;
        end else if (v < -t_sum'(Q_LIM)) begin
            sat_q = -Q_LIM;
        end else begin
            sat_q = v[QW-1:0];
        end
    endfunction

endpackage

>>> rtl/lur_dly.sv
// Enabled shift line that delays a word by DEPTH register stages.
module lur_dly #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_sh [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sh[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_sh[k] <= r_sh[k-1];
            end
        end
    end

    assign o_q = r_sh[DEPTH-1];

endmodule

>>> rtl/lur_mul.sv
// Four-stage signed fixed-point multiplier with round, shift and saturate.
module lur_mul
    import lur_pkg::*;
#(
    parameter int SHIFT = 28
) (
    input  logic i_clk,
    input  logic i_en,
    input  t_q   i_a,
    input  t_q   i_b,
    output t_q   o_p
);

    localparam int HW = QW / 2;
    localparam int PW = 2 * QW + 1;
    localparam int RW = PW - SHIFT;
    localparam logic [PW-1:0] RND = PW'(1) << (SHIFT - 1);

    logic              r_neg1;
    logic [QW-1:0]     r_ma;
    logic [QW-1:0]     r_mb;
    logic              r_neg2;
    logic [2*HW-1:0]   r_p00;
    logic [2*HW-1:0]   r_p01;
    logic [2*HW-1:0]   r_p10;
    logic [2*HW-1:0]   r_p11;
    logic              r_neg3;
    logic [PW-1:0]     r_sum;
    t_q                r_out;
    logic [RW-1:0]     n_mag;
    logic [QW-1:0]     n_lim;

    always_comb begin
        n_mag = r_sum[PW-1:SHIFT];
        n_lim = (n_mag > RW'(Q_LIM)) ? Q_LIM : n_mag[QW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Sign and magnitude.
            r_neg1 <= i_a[QW-1] ^ i_b[QW-1];
            r_ma   <= i_a[QW-1] ? QW'(-i_a) : QW'(i_a);
            r_mb   <= i_b[QW-1] ? QW'(-i_b) : QW'(i_b);
            // Partial products on half words.
            r_neg2 <= r_neg1;
            r_p00  <= r_ma[HW-1:0]  * r_mb[HW-1:0];
            r_p01  <= r_ma[HW-1:0]  * r_mb[QW-1:HW];
            r_p10  <= r_ma[QW-1:HW] * r_mb[HW-1:0];
            r_p11  <= r_ma[QW-1:HW] * r_mb[QW-1:HW];
            // Full product plus half an output LSB.
            r_neg3 <= r_neg2;
            r_sum  <= (PW'(r_p11) << (2 * HW)) + (PW'(r_p01) << HW)
                      + (PW'(r_p10) << HW) + PW'(r_p00) + RND;
            r_out  <= r_neg3 ? -$signed(n_lim) : $signed(n_lim);
        end
    end

    assign o_p = r_out;

endmodule

>>> rtl/lur_div.sv
// Pipelined restoring divider that normalizes a centered position by a focal length.
module lur_div
    import lur_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 8,
    localparam int DIFF_W = diff_mag_w(COORD_FRAC_BITS) + 1
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [DIFF_W-1:0] i_d,
    input  logic [FOCAL_W-1:0]       i_f,
    output t_q                       o_q
);

    localparam int MAG_W = DIFF_W - 1;
    localparam int SHN   = NORM_FRAC + FOCAL_FRAC - COORD_FRAC_BITS;
    localparam int NUM_W = MAG_W + SHN + 1;

    // Upper bits of r_w hold the numerator still to be consumed, lower bits the quotient.
    logic [NUM_W-1:0]   r_w   [0:NUM_W];
    logic [FOCAL_W-1:0] r_rem [0:NUM_W];
    logic               r_neg [0:NUM_W];
    logic               r_fz  [0:NUM_W];
    t_q                 r_q;

    logic [MAG_W-1:0]   n_mag;
    logic [NUM_W-1:0]   n_w   [1:NUM_W];
    logic [FOCAL_W-1:0] n_rem [1:NUM_W];
    logic [FOCAL_W:0]   n_try [1:NUM_W];
    logic               n_ge  [1:NUM_W];
    logic [NUM_W-1:0]   n_quo;
    logic [QW-1:0]      n_lim;

    always_comb begin
        n_mag = i_d[DIFF_W-1] ? MAG_W'(-i_d) : MAG_W'(i_d);
        for (int k = 1; k <= NUM_W; k++) begin
            n_try[k] = {r_rem[k-1], r_w[k-1][NUM_W-1]};
            n_ge[k]  = n_try[k] >= {1'b0, i_f};
            n_rem[k] = n_ge[k] ? FOCAL_W'(n_try[k] - {1'b0, i_f})
                               : n_try[k][FOCAL_W-1:0];
            n_w[k]   = {r_w[k-1][NUM_W-2:0], n_ge[k]};
        end
        n_quo = r_w[NUM_W];
        n_lim = (n_quo > NUM_W'(Q_LIM)) ? Q_LIM : n_quo[QW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Numerator is rounded by adding half the divisor up front.
            r_w[0]   <= NUM_W'({n_mag, {SHN{1'b0}}}) + NUM_W'(i_f >> 1);
            r_rem[0] <= '0;
            r_neg[0] <= i_d[DIFF_W-1];
            r_fz[0]  <= (i_f == '0);
            for (int k = 1; k <= NUM_W; k++) begin
                r_w[k]   <= n_w[k];
                r_rem[k] <= n_rem[k];
                r_neg[k] <= r_neg[k-1];
                r_fz[k]  <= r_fz[k-1];
            end
            if (r_fz[NUM_W]) begin
                r_q <= '0;
            end else begin
                r_q <= r_neg[NUM_W] ? -$signed(n_lim) : $signed(n_lim);
            end
        end
    end

    assign o_q = r_q;

endmodule

>>> rtl/lens_undistort_remap_coords.sv
// Top level of the lens remap block: config registers, pipeline and output stage.
//
// Maps an ideal pixel position (signed Q13.F) to its position in the distorted
// camera image using radial terms up to r^8 and two tangential terms.
// Input channel: i_in_valid with i_ideal_x/i_ideal_y; the block drives
// o_in_stall. Output channel: o_out_valid with o_warped_x, o_warped_y and
// o_inside_res; the receiver drives i_out_stall. A transaction completes on
// a clock edge with valid high and stall low.
// The block takes one transaction per cycle while the output is not stalled.
// Most of the pipeline depth is the one-bit-per-stage divider for the
// normalization, the chain of dependent multipliers the rest.
// Configuration goes through its own valid/ready write port, always ready;
// the user must write it only while no transaction is in flight, as the
// block itself does not enforce this.
// Reset clears the configuration registers and every stage's valid bit. When
// the receiver stalls a valid result, the whole pipeline holds and o_in_stall
// rises in the same cycle; no transaction is lost or repeated.
`include "lens_undistort_remap_coords_macros.svh"

module lens_undistort_remap_coords
    import lur_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic signed [POS_W-1:0] i_ideal_x,
    input  logic signed [POS_W-1:0] i_ideal_y,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [POS_W-1:0] o_warped_x,
    output logic signed [POS_W-1:0] o_warped_y,
    output logic                    o_inside_res,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int MAG_W   = diff_mag_w(COORD_FRAC_BITS);
    localparam int DIFF_W  = MAG_W + 1;
    localparam int BACK    = NORM_FRAC + FOCAL_FRAC - COORD_FRAC_BITS;
    localparam int NUM_W   = MAG_W + BACK + 1;
    localparam int DIV_LAT = NUM_W + 2;
    localparam int TN      = 1 + DIV_LAT;
    localparam int TOT     = TN + 30;
    localparam int CEN_W   = 13 + COORD_FRAC_BITS;
    localparam int PX_W    = QW + 1;

    // Configuration registers.
    logic [FOCAL_W-1:0]      r_fx, r_fy;
    logic [CEN_W-1:0]        r_cx, r_cy;
    logic signed [COEF_W-1:0] r_k1, r_k2, r_k3, r_k4, r_p1, r_p2;
    logic [DIM_W-1:0]        r_wd, r_ht;

    logic [TOT:0]            r_vld;
    logic                    en;
    logic                    nodist;

    logic signed [POS_W-1:0]  r_x, r_y;
    logic signed [DIFF_W-1:0] r_dx, r_dy;
    t_q nx, ny, xx, yy, xy;
    t_q r_rr, r_xx2, r_yy2, r_tx, r_ty;
    t_q r4, rk1, rr_d4, r6, r8, r4k2, r6k3, r8k4, rk1_d, r4k2_d;
    t_sum r_t1, r_t2;
    t_q r_s;
    logic [2*QW-1:0] nxy_d, txy_d;
    t_q xy_d;
    t_q snx, sny, p1tx, p2ty, p2xy, p1xy;
    t_q r_dxn, r_dyn, mx, my;
    logic [2*POS_W-1:0] pass_d;
    logic signed [PX_W-1:0] r_px, r_py;
    logic signed [PX_W-1:0] n_limx, n_limy;
    logic signed [POS_W-1:0] n_ox, n_oy;
    logic n_in;
    logic signed [POS_W-1:0] r_ox, r_oy;
    logic r_inside;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx <= '0; r_fy <= '0; r_cx <= '0; r_cy <= '0;
            r_k1 <= '0; r_k2 <= '0; r_k3 <= '0; r_k4 <= '0;
            r_p1 <= '0; r_p2 <= '0; r_wd <= '0; r_ht <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FOCAL: begin
                    r_fx <= i_cfg_data[FOCAL_W-1:0];
                    r_fy <= i_cfg_data[32 +: FOCAL_W];
                end
                CFG_CENTER: begin
                    r_cx <= i_cfg_data[CEN_W-1:0];
                    r_cy <= i_cfg_data[32 +: CEN_W];
                end
                CFG_K1: r_k1 <= i_cfg_data[COEF_W-1:0];
                CFG_K2: r_k2 <= i_cfg_data[COEF_W-1:0];
                CFG_K3: r_k3 <= i_cfg_data[COEF_W-1:0];
                CFG_K4: r_k4 <= i_cfg_data[COEF_W-1:0];
                CFG_TANGENT: begin
                    r_p1 <= i_cfg_data[COEF_W-1:0];
                    r_p2 <= i_cfg_data[32 +: COEF_W];
                end
                CFG_SIZE: begin
                    r_wd <= i_cfg_data[DIM_W-1:0];
                    r_ht <= i_cfg_data[DIM_W +: DIM_W];
                end
                default: begin
                end
            endcase
        end
    end

    // The whole pipeline advances together unless a finished result is held.
    assign en         = !(r_vld[TOT] && i_out_stall);
    assign o_in_stall = !en;
    assign nodist     = (r_k1 == '0) && (r_k2 == '0) && (r_k3 == '0) && (r_k4 == '0)
                        && (r_p1 == '0) && (r_p2 == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[TOT-1:0], i_in_valid};
        end
    end

    // Input capture and centering.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x  <= i_ideal_x;
            r_y  <= i_ideal_y;
            r_dx <= DIFF_W'(r_x) - DIFF_W'(r_cx);
            r_dy <= DIFF_W'(r_y) - DIFF_W'(r_cy);
        end
    end

    lur_div #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_div_x (
        .i_clk(i_clk), .i_en(en), .i_d(r_dx), .i_f(r_fx), .o_q(nx));
    lur_div #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_div_y (
        .i_clk(i_clk), .i_en(en), .i_d(r_dy), .i_f(r_fy), .o_q(ny));

    lur_mul #(.SHIFT(NORM_FRAC)) u_mul_xx (
        .i_clk(i_clk), .i_en(en), .i_a(nx), .i_b(nx), .o_p(xx));
    lur_mul #(.SHIFT(NORM_FRAC)) u_mul_yy (
        .i_clk(i_clk), .i_en(en), .i_a(ny), .i_b(ny), .o_p(yy));
    lur_mul #(.SHIFT(NORM_FRAC)) u_mul_xy (
        .i_clk(i_clk), .i_en(en), .i_a(nx), .i_b(ny), .o_p(xy));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rr  <= sat_q(t_sum'(xx) + t_sum'(yy));
            r_xx2 <= xx;
            r_yy2 <= yy;
            r_tx  <= sat_q(t_sum'(r_rr) + (t_sum'(r_xx2) <<< 1));
            r_ty  <= sat_q(t_sum'(r_rr) + (t_sum'(r_yy2) <<< 1));
        end
    end

    lur_mul #(.SHIFT(NORM_FRAC)) u_mul_r4 (
        .i_clk(i_clk), .i_en(en), .i_a(r_rr), .i_b(r_rr), .o_p(r4));
    lur_mul #(.SHIFT(NORM_FRAC)) u_mul_k1 (
        .i_clk(i_clk), .i_en(en), .i_a(r_rr), .i_b(t_q'(r_k1)), .o_p(rk1));

    lur_dly #(.WIDTH(QW), .DEPTH(4)) u_dly_rr (
        .i_clk(i_clk), .i_en(en), .i_d(r_rr), .o_q(rr_d4));

    lur_mul #(.SHIFT(NORM_FRAC)) u_mul_r6 (
        .i_clk(i_clk), .i_en(en), .i_a(r4), .i_b(rr_d4), .o_p(r6));
    lur_mul #(.SHIFT(NORM_FRAC)) u_mul_r8 (
        .i_clk(i_clk), .i_en(en), .i_a(r4), .i_b(r4), .o_p(r8));
    lur_mul #(.SHIFT(NORM_FRAC)) u_mul_k2 (
        .i_clk(i_clk), .i_en(en), .i_a(r4), .i_b(t_q'(r_k2)), .o_p(r4k2));
    lur_mul #(.SHIFT(NORM_FRAC)) u_mul_k3 (
        .i_clk(i_clk), .i_en(en), .i_a(r6), .i_b(t_q'(r_k3)), .o_p(r6k3));
    lur_mul #(.SHIFT(NORM_FRAC)) u_mul_k4 (
        .i_clk(i_clk), .i_en(en), .i_a(r8), .i_b(t_q'(r_k4)), .o_p(r8k4));

    lur_dly #(.WIDTH(QW), .DEPTH(8)) u_dly_rk1 (
        .i_clk(i_clk), .i_en(en), .i_d(rk1), .o_q(rk1_d));
    lur_dly #(.WIDTH(QW), .DEPTH(4)) u_dly_r4k2 (
        .i_clk(i_clk), .i_en(en), .i_d(r4k2), .o_q(r4k2_d));

    // Radial factor; the terms add exactly and saturate once at the end.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t1 <= t_sum'(Q_ONE) + t_sum'(rk1_d) + t_sum'(r4k2_d);
            r_t2 <= t_sum'(r6k3) + t_sum'(r8k4);
            r_s  <= sat_q(r_t1 + r_t2);
        end
    end

    lur_dly #(.WIDTH(2*QW), .DEPTH(19)) u_dly_nxy (
        .i_clk(i_clk), .i_en(en), .i_d({ny, nx}), .o_q(nxy_d));
    lur_dly #(.WIDTH(2*QW), .DEPTH(13)) u_dly_txy (
        .i_clk(i_clk), .i_en(en), .i_d({r_ty, r_tx}), .o_q(txy_d));
    lur_dly #(.WIDTH(QW), .DEPTH(15)) u_dly_xy (
        .i_clk(i_clk), .i_en(en), .i_d(xy), .o_q(xy_d));

    lur_mul #(.SHIFT(NORM_FRAC)) u_mul_snx (
        .i_clk(i_clk), .i_en(en), .i_a(r_s), .i_b(nxy_d[QW-1:0]), .o_p(snx));
    lur_mul #(.SHIFT(NORM_FRAC)) u_mul_sny (
        .i_clk(i_clk), .i_en(en), .i_a(r_s), .i_b(nxy_d[2*QW-1:QW]), .o_p(sny));
    lur_mul #(.SHIFT(NORM_FRAC)) u_mul_p1tx (
        .i_clk(i_clk), .i_en(en), .i_a(t_q'(r_p1)), .i_b(txy_d[QW-1:0]), .o_p(p1tx));
    lur_mul #(.SHIFT(NORM_FRAC)) u_mul_p2ty (
        .i_clk(i_clk), .i_en(en), .i_a(t_q'(r_p2)), .i_b(txy_d[2*QW-1:QW]), .o_p(p2ty));
    lur_mul #(.SHIFT(NORM_FRAC)) u_mul_p2xy (
        .i_clk(i_clk), .i_en(en), .i_a(t_q'(r_p2)), .i_b(xy_d), .o_p(p2xy));
    lur_mul #(.SHIFT(NORM_FRAC)) u_mul_p1xy (
        .i_clk(i_clk), .i_en(en), .i_a(t_q'(r_p1)), .i_b(xy_d), .o_p(p1xy));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dxn <= sat_q(t_sum'(snx) + t_sum'(p1tx) + (t_sum'(p2xy) <<< 1));
            r_dyn <= sat_q(t_sum'(sny) + t_sum'(p2ty) + (t_sum'(p1xy) <<< 1));
        end
    end

    lur_mul #(.SHIFT(BACK)) u_mul_fx (
        .i_clk(i_clk), .i_en(en), .i_a(r_dxn), .i_b(t_q'(r_fx)), .o_p(mx));
    lur_mul #(.SHIFT(BACK)) u_mul_fy (
        .i_clk(i_clk), .i_en(en), .i_a(r_dyn), .i_b(t_q'(r_fy)), .o_p(my));

    // The original position rides along for the no-distortion bypass.
    lur_dly #(.WIDTH(2*POS_W), .DEPTH(DIV_LAT + 29)) u_dly_pass (
        .i_clk(i_clk), .i_en(en), .i_d({r_y, r_x}), .o_q(pass_d));

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (nodist) begin
                r_px <= PX_W'($signed(pass_d[POS_W-1:0]));
                r_py <= PX_W'($signed(pass_d[2*POS_W-1:POS_W]));
            end else begin
                r_px <= PX_W'(mx) + $signed({{(PX_W-CEN_W){1'b0}}, r_cx});
                r_py <= PX_W'(my) + $signed({{(PX_W-CEN_W){1'b0}}, r_cy});
            end
        end
    end

    // Output stage: saturate to the output format and test the image bounds.
    always_comb begin
        n_limx = $signed(PX_W'({DIM_W'(r_wd - 1'b1), {COORD_FRAC_BITS{1'b0}}}));
        n_limy = $signed(PX_W'({DIM_W'(r_ht - 1'b1), {COORD_FRAC_BITS{1'b0}}}));
        if ((&r_px[PX_W-1:POS_W-1]) || !(|r_px[PX_W-1:POS_W-1])) begin
            n_ox = r_px[POS_W-1:0];
        end else begin
            n_ox = r_px[PX_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end
        if ((&r_py[PX_W-1:POS_W-1]) || !(|r_py[PX_W-1:POS_W-1])) begin
            n_oy = r_py[POS_W-1:0];
        end else begin
            n_oy = r_py[PX_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end
        n_in = (r_wd != '0) && (r_ht != '0) && !r_px[PX_W-1] && !r_py[PX_W-1]
               && (r_px <= n_limx) && (r_py <= n_limy);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ox     <= n_ox;
            r_oy     <= n_oy;
            r_inside <= n_in;
        end
    end

    assign o_out_valid  = r_vld[TOT];
    assign o_warped_x   = r_ox;
    assign o_warped_y   = r_oy;
    assign o_inside_res = r_inside;

    `LUR_ASSERT_NEXT(a_stall_freezes, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(r_vld))
    `LUR_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_vld[0])
    `LUR_ASSERT_NOW(a_inside_nonneg, i_clk, i_rst_n, o_out_valid && o_inside_res, !o_warped_x[POS_W-1] && !o_warped_y[POS_W-1])

endmodule

>>> bench/lens_remap_checker.sv
// Scoreboard for the lens remap block: shadow registers, position predictor and output compare.
module lens_remap_checker
    import lur_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  logic signed [POS_W-1:0] i_ideal_x,
    input  logic signed [POS_W-1:0] i_ideal_y,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  logic signed [POS_W-1:0] i_warped_x,
    input  logic signed [POS_W-1:0] i_warped_y,
    input  logic                    i_inside_res,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    output int                      o_fail_count,
    output int                      o_open_count
);

    localparam longint LIM = 64'h0000_7FFF_FFFF_FFFF;
    localparam longint POS_MAX = 2097151;
    localparam longint POS_MIN = -2097152;
    localparam int BACK_SHIFT = NORM_FRAC + FOCAL_FRAC - COORD_FRAC_BITS;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic                    on_image;
    } t_warp;

    logic [63:0] focal_q, center_q, tangent_q;
    logic [31:0] k1_q, k2_q, k3_q, k4_q, size_q;
    t_warp       warp_queue[$];
    int          fail_count;

    assign o_fail_count = fail_count;
    assign o_open_count = warp_queue.size();

    function automatic logic [63:0] magnitude(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint clamp_q(longint v);
        if (v > LIM) return LIM;
        if (v < -LIM) return -LIM;
        return v;
    endfunction

    // Product shifted right with rounding half away from zero, then saturated.
    function automatic longint mul_round(longint a, longint b, int sh);
        logic [127:0] prod;
        logic [127:0] r;
        prod = 128'(magnitude(a)) * 128'(magnitude(b));
        r = (prod + (128'd1 << (sh - 1))) >> sh;
        if (r > 128'(LIM)) r = 128'(LIM);
        return ((a < 0) != (b < 0)) ? -longint'(r[63:0]) : longint'(r[63:0]);
    endfunction

    function automatic longint mq(longint a, longint b);
        return mul_round(a, b, NORM_FRAC);
    endfunction

    function automatic longint norm_axis(longint d, logic [63:0] f);
        logic [63:0] num;
        logic [63:0] q;
        if (f == 0) return 0;
        num = magnitude(d) << BACK_SHIFT;
        q = (num + (f >> 1)) / f;
        if (q > 64'(LIM)) q = 64'(LIM);
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [POS_W-1:0] clip_pos(longint v);
        if (v > POS_MAX) v = POS_MAX;
        if (v < POS_MIN) v = POS_MIN;
        return v[POS_W-1:0];
    endfunction

    function automatic t_warp predict_warp(longint x, longint y);
        longint cx, cy, k1, k2, k3, k4, p1, p2, px, py, w, h;
        longint nx, ny, xx, yy, xy, rr, r4, r6, r8, s, dx, dy;
        logic [63:0] fx, fy;
        t_warp res;
        cx = longint'(center_q[12+COORD_FRAC_BITS:0]);
        cy = longint'(center_q[44+COORD_FRAC_BITS:32]);
        fx = 64'(focal_q[23:0]);
        fy = 64'(focal_q[55:32]);
        k1 = longint'($signed(k1_q));
        k2 = longint'($signed(k2_q));
        k3 = longint'($signed(k3_q));
        k4 = longint'($signed(k4_q));
        p1 = longint'($signed(tangent_q[31:0]));
        p2 = longint'($signed(tangent_q[63:32]));
        w = longint'(size_q[15:0]);
        h = longint'(size_q[31:16]);
        px = x;
        py = y;
        if (k1 != 0 || k2 != 0 || k3 != 0 || k4 != 0 || p1 != 0 || p2 != 0) begin
            nx = norm_axis(x - cx, fx);
            ny = norm_axis(y - cy, fy);
            xx = mq(nx, nx);
            yy = mq(ny, ny);
            xy = mq(nx, ny);
            rr = clamp_q(xx + yy);
            r4 = mq(rr, rr);
            r6 = mq(r4, rr);
            r8 = mq(r4, r4);
            s = clamp_q((longint'(1) << NORM_FRAC) + mq(rr, k1) + mq(r4, k2)
                        + mq(r6, k3) + mq(r8, k4));
            dx = clamp_q(mq(s, nx) + mq(p1, clamp_q(rr + 2 * xx)) + 2 * mq(p2, xy));
            dy = clamp_q(mq(s, ny) + mq(p2, clamp_q(rr + 2 * yy)) + 2 * mq(p1, xy));
            px = mul_round(dx, longint'(fx), BACK_SHIFT) + cx;
            py = mul_round(dy, longint'(fy), BACK_SHIFT) + cy;
        end
        res.on_image = w > 0 && h > 0 && px >= 0 && py >= 0
                       && px <= ((w - 1) << COORD_FRAC_BITS)
                       && py <= ((h - 1) << COORD_FRAC_BITS);
        res.x = clip_pos(px);
        res.y = clip_pos(py);
        return res;
    endfunction

    task automatic report(string what);
        $display("[%0d] mismatch: %s", $time, what);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge i_clk) begin
        t_warp want;
        if (!i_rst_n) begin
            focal_q <= '0; center_q <= '0; tangent_q <= '0;
            k1_q <= '0; k2_q <= '0; k3_q <= '0; k4_q <= '0; size_q <= '0;
            warp_queue.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                warp_queue.push_back(predict_warp(longint'(i_ideal_x),
                                                  longint'(i_ideal_y)));
            end
            if (i_out_valid && !i_out_stall) begin
                if (warp_queue.size() == 0) begin
                    report("result with nothing expected");
                end else begin
                    want = warp_queue.pop_front();
                    if (i_warped_x !== want.x)
                        report($sformatf("warped_x %0d, expected %0d", i_warped_x, want.x));
                    if (i_warped_y !== want.y)
                        report($sformatf("warped_y %0d, expected %0d", i_warped_y, want.y));
                    if (i_inside_res !== want.on_image)
                        report($sformatf("inside_res %0b, expected %0b",
                                         i_inside_res, want.on_image));
                end
            end
            // Register updates land after this edge's input was predicted.
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FOCAL:   focal_q <= i_cfg_data;
                    CFG_CENTER:  center_q <= i_cfg_data;
                    CFG_K1:      k1_q <= i_cfg_data[31:0];
                    CFG_K2:      k2_q <= i_cfg_data[31:0];
                    CFG_K3:      k3_q <= i_cfg_data[31:0];
                    CFG_K4:      k4_q <= i_cfg_data[31:0];
                    CFG_TANGENT: tangent_q <= i_cfg_data;
                    CFG_SIZE:    size_q <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> bench/lens_undistort_remap_coords_tb.sv
// Testbench top for the lens remap block: stimulus, configuration phases and verdict.
module lens_undistort_remap_coords_tb;
    import lur_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd11;
    localparam int DRAIN_CYCLES = 100;
    localparam int STALL_LIMIT = 3000;
    localparam int RANDOM_PER_SET = 140;

    logic                    i_clk, i_rst_n;
    logic                    i_in_valid, o_in_stall;
    logic signed [POS_W-1:0] i_ideal_x, i_ideal_y;
    logic                    o_out_valid, i_out_stall;
    logic signed [POS_W-1:0] o_warped_x, o_warped_y;
    logic                    o_inside_res;
    logic                    i_cfg_valid, o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    int                      fail_count, open_count;
    int                      send_idle_pct, recv_idle_pct;
    int                      quiet_cycles, items_sent;
    logic [31:0]             size_now;

    lens_undistort_remap_coords dut (.*);

    lens_remap_checker scoreboard (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_ideal_x, .i_ideal_y,
        .i_out_valid(o_out_valid), .i_out_stall, .i_warped_x(o_warped_x),
        .i_warped_y(o_warped_y), .i_inside_res(o_inside_res), .i_cfg_valid,
        .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_open_count(open_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Any accepted transaction on any channel counts as progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic send_pos(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_ideal_x <= x;
        i_ideal_y <= y;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (open_count != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_SIZE) size_now = data[31:0];
    endtask

    task automatic load_lens(logic [63:0] f, logic [63:0] c, logic [31:0] k1,
                             logic [31:0] k2, logic [31:0] k3, logic [31:0] k4,
                             logic [63:0] p, logic [31:0] sz);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        write_reg(CFG_FOCAL, f);
        write_reg(CFG_CENTER, c);
        write_reg(CFG_K1, {$urandom, k1});
        write_reg(CFG_K2, {$urandom, k2});
        write_reg(CFG_K3, {$urandom, k3});
        write_reg(CFG_K4, {$urandom, k4});
        write_reg(CFG_TANGENT, p);
        write_reg(CFG_SIZE, {$urandom, sz});
    endtask

    function automatic logic [31:0] small_coef();
        return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
    endfunction

    // Mostly positions on or around the image, the rest anywhere in the field range.
    task automatic send_random();
        logic signed [POS_W-1:0] x, y;
        if ($urandom_range(99) < 70) begin
            x = POS_W'($urandom_range(0, (32'(size_now[15:0]) + 8) << 8)) - 22'sd512;
            y = POS_W'($urandom_range(0, (32'(size_now[31:16]) + 8) << 8)) - 22'sd512;
        end else begin
            x = POS_W'($urandom);
            y = POS_W'($urandom);
        end
        send_pos(x, y);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_ideal_x = '0;
        i_ideal_y = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_FOCAL;
        i_cfg_data = '0;
        items_sent = 0;
        size_now = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset registers pass positions through, zero size is never inside.
        send_pos(22'sd0, 22'sd0);
        send_pos(22'sh1FFFFF, 22'sh1FFFFF);
        send_pos(-22'sh200000, -22'sh200000);
        send_pos(22'sh1FFFFF, -22'sh200000);
        send_pos(-22'sd1, 22'sd1);
        send_pos(22'sh2AAAAA, 22'sh155555);

        // Directed with a typical lens and the image edges.
        load_lens({32'd500 << 8, 32'd520 << 8}, {32'd240 << 8, 32'd320 << 8},
                  32'sh0100_0000, -32'sh0040_0000, 32'sh0001_0000, -32'sh0000_1000,
                  {32'sh0000_8000, -32'sh0000_4000}, {16'd480, 16'd640});
        send_pos(22'sd0, 22'sd0);
        send_pos(22'sd639 << 8, 22'sd479 << 8);
        send_pos(22'sd640 << 8, 22'sd480 << 8);
        send_pos(-22'sd1, 22'sd10);
        send_pos(22'sd320 << 8, 22'sd240 << 8);
        send_pos(22'sh1FFFFF, -22'sh200000);
        // Writes to an index beyond the map leave everything alone.
        wait_drained();
        write_reg(CFG_UNUSED, '1);
        send_pos(22'sd100 << 8, 22'sd50 << 8);

        // Extremes: largest coefficients, focal lengths and center, full size.
        load_lens('1, '1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  {32'h8000_0000, 32'h7FFF_FFFF}, 32'hFFFF_FFFF);
        send_pos(22'sh1FFFFF, 22'sh1FFFFF);
        send_pos(-22'sh200000, -22'sh200000);
        send_pos(22'sd0, 22'sd0);
        // Zero focal length with distortion on, and a zero-height image.
        load_lens(64'd0, {32'd100 << 8, 32'd100 << 8}, 32'sh0100_0000, 32'd0, 32'd0,
                  32'd0, 64'd0, {16'd0, 16'd200});
        send_pos(22'sd50 << 8, 22'sd50 << 8);
        send_pos(-22'sh200000, 22'sh1FFFFF);

        for (int set = 0; set < 5; set++) begin
            case (set)
                0: load_lens({32'd600 << 8, 32'd600 << 8}, {32'd240 << 8, 32'd320 << 8},
                             small_coef(), small_coef(), small_coef(), small_coef(),
                             {small_coef(), small_coef()}, {16'd480, 16'd640});
                1: load_lens({32'($urandom_range(64, 4000)) << 8,
                              32'($urandom_range(64, 4000)) << 8},
                             {32'($urandom_range(0, 1000)) << 8,
                              32'($urandom_range(0, 1000)) << 8},
                             small_coef(), small_coef(), small_coef(), small_coef(),
                             {small_coef(), small_coef()},
                             {16'($urandom_range(1, 1500)), 16'($urandom_range(1, 2000))});
                2: load_lens({32'd900 << 8, 32'd900 << 8}, {32'd360 << 8, 32'd640 << 8},
                             small_coef(), 32'd0, 32'd0, 32'd0, 64'd0,
                             {16'd720, 16'd1280});
                3: load_lens({$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                             $urandom, $urandom, $urandom, {$urandom, $urandom}, $urandom);
                default: load_lens({32'd700 << 8, 32'd10 << 8}, {32'd300 << 8, 32'd2 << 8},
                                   small_coef(), small_coef(), 32'd0, 32'd0,
                                   {small_coef(), 32'd0}, {16'd1, 16'd600});
            endcase
            for (int n = 0; n < RANDOM_PER_SET; n++) begin
                if (items_sent < 260) begin
                    send_idle_pct = 28; recv_idle_pct = 51;
                end else if (items_sent < 500) begin
                    send_idle_pct = 51; recv_idle_pct = 28;
                end else begin
                    send_idle_pct = 0; recv_idle_pct = 0;
                end
                // Let the pipeline empty completely once mid-stream.
                if (set == 1 && n == 60) wait_drained();
                send_random();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d positions over nine lens settings, from pass-through to extremes,",
                 items_sent);
        $display("with sender and receiver stalls in both proportions and at full rate.");
        if (fail_count == 0 && open_count == 0) begin
            $display("SUCCESS");
        end else begin
            if (open_count != 0) $display("%0d results never arrived", open_count);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
